// ----- sv/rmf_pkg.sv -----
`default_nettype none

package rmf_pkg;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_MERGE_GAP     = 8'd0,
    CFG_SCORE_CUTOFF  = 8'd1,
    CFG_CUTOFF_ENABLE = 8'd2,
    CFG_MIN_WIDTH     = 8'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] MergeGapRst     = 32'd1;
  localparam logic [15:0] ScoreCutoffRst  = 16'd655;
  localparam logic        CutoffEnableRst = 1'b1;
  localparam logic [31:0] MinWidthRst     = 32'd0;

  typedef struct packed {
    logic [31:0] merge_gap;
    logic [15:0] score_cutoff;
    logic        cutoff_enable;
    logic [31:0] min_width;
  } cfg_t;

  // Packed so that the chromosome lands in the lowest bits of tdata.
  typedef struct packed {
    logic [15:0] region_score;
    logic [31:0] region_end;
    logic [31:0] region_start;
    logic [7:0]  chrom_id;
  } region_t;

  localparam int unsigned DataW = $bits(region_t);

  typedef struct packed {
    logic    run_last;
    region_t region;
  } result_t;

  // Up to two results leave the merge stage per item, always packed from slot 0.
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  function automatic logic region_passes(region_t r, cfg_t c);
    logic [31:0] width;
    logic        score_ok;
    width    = (r.region_end >= r.region_start) ? (r.region_end - r.region_start) : 32'd0;
    score_ok = !c.cutoff_enable || (r.region_score < c.score_cutoff);
    return score_ok && (width >= c.min_width);
  endfunction

endpackage

`default_nettype wire

// ----- sv/region_merge_and_filter.sv -----
`default_nettype none
// Latency: a result beat passes through the input register and then the result queue before it is offered.
// Throughput: one input beat per cycle while each item yields at most one result and the output
// keeps taking results; an item that closes one region and flushes another yields two beats, and
// the four-entry result queue throttles the input until the output has taken them.
// Reset (rst_ni low, asynchronous): no open region, queue empty, registers at their defaults.

module region_merge_and_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  // Region stream in.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: chrom_id[7:0], region_start[31:0], region_end[31:0],
  // region_score[15:0].
  input  wire logic [rmf_pkg::DataW-1:0]      s_axis_tdata,
  // tlast carries list_last.
  input  wire logic                           s_axis_tlast,

  // Merged region stream out.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata, low bit up: out_chrom[7:0], out_start[31:0], out_end[31:0], out_score[15:0].
  output logic [rmf_pkg::DataW-1:0]           m_axis_tdata,
  // tlast carries run_last.
  output logic                                m_axis_tlast,

  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rmf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rmf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import rmf_pkg::*;

  cfg_t    cfg;
  push_t   push;
  logic    q_room;
  result_t out_res;

  // Configuration register file. Writes to unknown indexes are dropped.
  rmf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The merge stage holds the single open region. Each accepted beat is registered, then,
  // once the queue has room, it either extends the open region or closes it and opens a new
  // one. Closed and flushed regions that pass the score and width filters go to the queue.
  rmf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_region_i (region_t'(s_axis_tdata)),
    .in_last_i   (s_axis_tlast),
    .q_room_i    (q_room),
    .push_o      (push)
  );

  // The result queue decouples the output from the merge stage, so an input beat can be
  // taken while a finished region still waits for the downstream ready.
  rmf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (q_room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = out_res.region;
  assign m_axis_tlast = out_res.run_last;

endmodule

`default_nettype wire

// ----- sv/rmf_cfg.sv -----
`default_nettype none

module rmf_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rmf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rmf_pkg::CfgDataW-1:0]   cfg_data_i,
  output rmf_pkg::cfg_t                       cfg_o
);
  import rmf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MERGE_GAP:     cfg_d.merge_gap     = cfg_data_i;
        CFG_SCORE_CUTOFF:  cfg_d.score_cutoff  = cfg_data_i[15:0];
        CFG_CUTOFF_ENABLE: cfg_d.cutoff_enable = cfg_data_i[0];
        CFG_MIN_WIDTH:     cfg_d.min_width     = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_gap     <= MergeGapRst;
      cfg_q.score_cutoff  <= ScoreCutoffRst;
      cfg_q.cutoff_enable <= CutoffEnableRst;
      cfg_q.min_width     <= MinWidthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/rmf_merge.sv -----
`default_nettype none

module rmf_merge (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rmf_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rmf_pkg::region_t in_region_i,
  input  wire logic             in_last_i,
  input  wire logic             q_room_i,
  output rmf_pkg::push_t        push_o
);
  import rmf_pkg::*;

  logic    in_valid_q;
  region_t in_region_q;
  logic    in_last_q;

  logic    open_valid_q, open_valid_d;
  region_t open_q, open_d;

  logic    fire;
  logic    merge;
  logic    close_ok;
  logic    flush_ok;
  region_t merged;

  // The item in the input register is processed once the queue has room for two results.
  assign fire       = in_valid_q && q_room_i;
  assign in_ready_o = !in_valid_q || q_room_i;

  // The gap sum is formed at 33 bits so it never wraps.
  assign merge = open_valid_q && (open_q.chrom_id == in_region_q.chrom_id) &&
                 (({1'b0, open_q.region_end} + {1'b0, cfg_i.merge_gap}) >=
                  {1'b0, in_region_q.region_start});

  always_comb begin
    merged = open_q;
    if (in_region_q.region_end > open_q.region_end) begin
      merged.region_end = in_region_q.region_end;
    end
    if (in_region_q.region_score < open_q.region_score) begin
      merged.region_score = in_region_q.region_score;
    end
  end

  always_comb begin
    open_d       = merge ? merged : in_region_q;
    open_valid_d = !in_last_q;
  end

  assign close_ok = !merge && open_valid_q && region_passes(open_q, cfg_i);
  assign flush_ok = in_last_q && region_passes(open_d, cfg_i);

  always_comb begin
    push_o.vld0            = fire && (close_ok || flush_ok);
    push_o.vld1            = fire && close_ok && flush_ok;
    push_o.res0.region     = close_ok ? open_q : open_d;
    push_o.res0.run_last   = !(close_ok && flush_ok);
    push_o.res1.region     = open_d;
    push_o.res1.run_last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      open_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        open_valid_q <= open_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_region_q <= in_region_i;
      in_last_q   <= in_last_i;
    end
    if (fire) begin
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rmf_outq.sv -----
`default_nettype none

module rmf_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rmf_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rmf_pkg::result_t      out_o
);
  import rmf_pkg::*;

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  logic [QPtrW-1:0] wr_ptr_nxt;
  logic [QCntW-1:0] push_n;

  assign room_o      = cnt_q <= QCntW'(QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nxt  = wr_ptr_q + QPtrW'(1);
  assign push_n      = QCntW'(push_i.vld0) + QCntW'(push_i.vld1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[QPtrW-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + push_n - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule

`default_nettype wire
